### src/wpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpm_pkg
// Shared types and constants of the wildcard pattern matcher.
// ----------------------------------------------------------------------------
package wpm_pkg;

    localparam int MAX_PATTERN_DEF = 64;
    localparam int SYMBOL_W        = 8;
    localparam int CMD_W           = 2;

    localparam logic [SYMBOL_W-1:0] SYM_STAR = 8'h2A;
    localparam logic [SYMBOL_W-1:0] SYM_ANY  = 8'h3F;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_BEGIN  = 2'd2,
        CMD_TEXT   = 2'd3
    } cmd_t;

    // One strobe per command, high only in the cycle the item is processed.
    typedef struct packed {
        logic clear;
        logic append;
        logic begin_text;
        logic text_byte;
    } wpm_ctrl_t;

endpackage

### src/wpm_pattern_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpm_pattern_store
// Pattern byte storage, length counter, overflow flag and per-position masks.
// ----------------------------------------------------------------------------
module wpm_pattern_store #(
    parameter int MAX_PATTERN = wpm_pkg::MAX_PATTERN_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  wpm_pkg::wpm_ctrl_t                          ctrl,
    input  logic [wpm_pkg::SYMBOL_W-1:0]                symbol,
    output logic [MAX_PATTERN-1:0][wpm_pkg::SYMBOL_W-1:0] pattern,
    output logic [MAX_PATTERN-1:0]                      star_mask,
    output logic [MAX_PATTERN-1:0]                      any_mask,
    output logic [MAX_PATTERN-1:0]                      len_mask,
    output logic [MAX_PATTERN-1:0]                      last_mask,
    output logic                                        empty_pattern,
    output logic                                        full,
    output logic                                        overflow
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic [MAX_PATTERN-1:0][wpm_pkg::SYMBOL_W-1:0] pattern_reg;
    logic [LEN_W-1:0] length_reg, length_next;
    logic             overflow_reg, overflow_next;
    logic             room;

    assign room = (length_reg < LEN_W'(MAX_PATTERN));

    always_comb
    begin
        length_next   = length_reg;
        overflow_next = overflow_reg;
        if (ctrl.clear)
        begin
            length_next   = '0;
            overflow_next = 1'b0;
        end
        else if (ctrl.append)
        begin
            if (room)
                length_next = length_reg + LEN_W'(1);
            else
                overflow_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg   <= '0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            length_reg   <= length_next;
            overflow_reg <= overflow_next;
        end
    end

    // Payload storage: written on each append that finds room, no reset.
    always_ff @(posedge clk)
    begin
        if (ctrl.append && room)
            pattern_reg[length_reg[IDX_W-1:0]] <= symbol;
    end

    always_comb
    begin
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            star_mask[k] = (pattern_reg[k] == wpm_pkg::SYM_STAR);
            any_mask[k]  = (pattern_reg[k] == wpm_pkg::SYM_ANY);
            len_mask[k]  = (length_reg > LEN_W'(k));
            last_mask[k] = (length_reg == LEN_W'(k + 1));
        end
    end

    assign pattern       = pattern_reg;
    assign empty_pattern = (length_reg == '0);
    assign full          = ~room;
    assign overflow      = overflow_reg;

endmodule

### src/wpm_prefix_row.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpm_prefix_row
// Prefix match row with a parallel segmented scan across runs of stars.
// ----------------------------------------------------------------------------
module wpm_prefix_row #(
    parameter int MAX_PATTERN = wpm_pkg::MAX_PATTERN_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  wpm_pkg::wpm_ctrl_t                            ctrl,
    input  logic [wpm_pkg::SYMBOL_W-1:0]                  symbol,
    input  logic [MAX_PATTERN-1:0][wpm_pkg::SYMBOL_W-1:0] pattern,
    input  logic [MAX_PATTERN-1:0]                        star_mask,
    input  logic [MAX_PATTERN-1:0]                        any_mask,
    input  logic [MAX_PATTERN-1:0]                        len_mask,
    input  logic [MAX_PATTERN-1:0]                        last_mask,
    input  logic                                          empty_pattern,
    output logic                                          matched_next
);

    localparam int LEVELS = $clog2(MAX_PATTERN);

    logic [MAX_PATTERN-1:0] prefix_row_reg, prefix_row_next;
    logic                   empty_live_reg, empty_live_next;
    logic [MAX_PATTERN-1:0] gen_lvl [0:LEVELS];
    logic [MAX_PATTERN-1:0] prop_lvl [0:LEVELS];
    logic                   left_old;

    // Non-star positions settle from old bits only; star positions extend
    // the nearest live entry to their left, so the scan carries it upward.
    always_comb
    begin
        left_old = 1'b0;
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            left_old = (k == 0) ? empty_live_reg : prefix_row_reg[(k > 0) ? k - 1 : 0];
            prop_lvl[0][k] = star_mask[k];
            if (ctrl.begin_text)
                gen_lvl[0][k] = (k == 0) && star_mask[k];
            else if (star_mask[k])
                gen_lvl[0][k] = prefix_row_reg[k];
            else
                gen_lvl[0][k] = left_old && (any_mask[k] || (pattern[k] == symbol));
        end
        for (int l = 0; l < LEVELS; l++)
        begin
            for (int k = 0; k < MAX_PATTERN; k++)
            begin
                if (k >= (1 << l))
                begin
                    gen_lvl[l+1][k]  = gen_lvl[l][k]
                                     | (prop_lvl[l][k] & gen_lvl[l][k - (1 << l)]);
                    prop_lvl[l+1][k] = prop_lvl[l][k] & prop_lvl[l][k - (1 << l)];
                end
                else
                begin
                    gen_lvl[l+1][k]  = gen_lvl[l][k];
                    prop_lvl[l+1][k] = prop_lvl[l][k];
                end
            end
        end
    end

    always_comb
    begin
        prefix_row_next = prefix_row_reg;
        empty_live_next = empty_live_reg;
        if (ctrl.clear || ctrl.append)
        begin
            prefix_row_next = '0;
            empty_live_next = 1'b0;
        end
        else if (ctrl.begin_text || ctrl.text_byte)
        begin
            prefix_row_next = gen_lvl[LEVELS] & len_mask;
            empty_live_next = ctrl.begin_text;
        end
    end

    assign matched_next = empty_pattern ? empty_live_next
                                        : |(prefix_row_next & last_mask);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_row_reg <= '0;
            empty_live_reg <= 1'b0;
        end
        else
        begin
            prefix_row_reg <= prefix_row_next;
            empty_live_reg <= empty_live_next;
        end
    end

    // Prefixes longer than the pattern never match.
    a_row_in_length: assert property (@(posedge clk) disable iff (!rst_n)
        (prefix_row_reg & ~len_mask) == '0)
        else $error("prefix row bit set beyond pattern length");

endmodule

### src/wildcard_pattern_matcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_pattern_matcher
// Streams text bytes against a stored pattern with '?' and '*' wildcards.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  s_axis    in         tuser[1:0] command, tdata[7:0] symbol
//  m_axis    out        tdata[0] matched, tdata[1] overflow, tdata[7:2] zero
//
//  One transaction per cycle while no result stalls: an item is registered on
//  accept and processed by the prefix row scan once it advances out of the
//  input register. The result register loads on that advance, so a result
//  passes the input register and then the result register before it leaves.
//  Clear and append commands yield no result; begin-text and text-byte do.
//  A stalled result holds the output register; the input register still
//  takes an item and advances whenever that item yields no result.
//  Reset empties the pattern and both pipeline registers.
// ----------------------------------------------------------------------------
module wildcard_pattern_matcher #(
    parameter int MAX_PATTERN = wpm_pkg::MAX_PATTERN_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] symbol
    input  logic [1:0] s_axis_tuser,   // [1:0] command
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [0] matched, [1] overflow, [7:2] zero
);

    // Input register
    logic                           in_valid_reg, in_valid_next;
    wpm_pkg::cmd_t                  in_cmd_reg;
    logic [wpm_pkg::SYMBOL_W-1:0]   in_sym_reg;

    // Result register
    logic out_valid_reg, out_valid_next;
    logic out_matched_reg;
    logic out_overflow_reg;

    logic               yields;
    logic               advance;
    logic               in_fire;
    wpm_pkg::wpm_ctrl_t ctrl;

    logic [MAX_PATTERN-1:0][wpm_pkg::SYMBOL_W-1:0] pattern;
    logic [MAX_PATTERN-1:0] star_mask;
    logic [MAX_PATTERN-1:0] any_mask;
    logic [MAX_PATTERN-1:0] len_mask;
    logic [MAX_PATTERN-1:0] last_mask;
    logic                   empty_pattern;
    logic                   full;
    logic                   overflow;
    logic                   matched_next;

    // Decode the held command into one-cycle strobes.
    always_comb
    begin
        yields = 1'b0;
        ctrl   = '0;
        unique case (in_cmd_reg)
            wpm_pkg::CMD_CLEAR:  ctrl.clear      = advance;
            wpm_pkg::CMD_APPEND: ctrl.append     = advance;
            wpm_pkg::CMD_BEGIN:
            begin
                yields          = 1'b1;
                ctrl.begin_text = advance;
            end
            wpm_pkg::CMD_TEXT:
            begin
                yields         = 1'b1;
                ctrl.text_byte = advance;
            end
        endcase
    end

    // Advance unless the item has a result and the result register is stuck.
    assign advance       = in_valid_reg && (!yields || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_fire)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance && yields)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: capture on accept, load result on advance.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_cmd_reg <= wpm_pkg::cmd_t'(s_axis_tuser);
            in_sym_reg <= s_axis_tdata;
        end
        if (advance && yields)
        begin
            out_matched_reg  <= matched_next;
            out_overflow_reg <= overflow;
        end
    end

    wpm_pattern_store #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_store (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .symbol        (in_sym_reg),
        .pattern       (pattern),
        .star_mask     (star_mask),
        .any_mask      (any_mask),
        .len_mask      (len_mask),
        .last_mask     (last_mask),
        .empty_pattern (empty_pattern),
        .full          (full),
        .overflow      (overflow)
    );

    wpm_prefix_row #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_row (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .symbol        (in_sym_reg),
        .pattern       (pattern),
        .star_mask     (star_mask),
        .any_mask      (any_mask),
        .len_mask      (len_mask),
        .last_mask     (last_mask),
        .empty_pattern (empty_pattern),
        .matched_next  (matched_next)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_overflow_reg, out_matched_reg};

    // A result-producing item always lands in the result register.
    a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && yields) |=> out_valid_reg)
        else $error("result dropped on advance");

    // Overflow can only be raised once the pattern store is full.
    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        overflow |-> full)
        else $error("overflow flagged while store has room");

    // A clear empties the pattern and drops the overflow flag.
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.clear |=> (empty_pattern && !overflow))
        else $error("clear left pattern state behind");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the wildcard pattern matcher. A directed table walks
// the corner cases, then random pattern/text sessions with random idle cycles
// on both stream sides. Every result transaction is compared with a local
// prefix-row predictor or with the flags typed into the directed table.
// ----------------------------------------------------------------------------
module tb;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 9;
    localparam int RANDOM_ITEMS = 2000;
    localparam int DRAIN_CYCLES = 16;
    localparam int MAX_REPORTS  = 40;
    localparam int HOLD_AFTER   = 400;   // results seen before the long sink stall
    localparam int HOLD_CYCLES  = 300;

    typedef struct packed {
        logic matched;
        logic overflow;
    } match_flags_t;

    typedef struct {
        wpm_pkg::cmd_t cmd;
        logic [7:0]    sym;
        int            reps;
        bit            fixed;   // expected flags typed in below, not predicted
        match_flags_t  flags;
    } stim_row_t;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = '0;                 // [7:0] symbol
    logic [1:0] s_axis_tuser  = wpm_pkg::CMD_CLEAR; // [1:0] command
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;              // [0] matched, [1] overflow, [7:2] zero

    // Predictor state: mirrors the pattern store and the prefix bit row.
    logic [7:0]   pat_mem [wpm_pkg::MAX_PATTERN_DEF];
    int unsigned  pat_len    = 0;
    logic [63:0]  live_row   = '0;
    logic         empty_live = 1'b0;
    logic         dropped    = 1'b0;

    match_flags_t pending_flags [$];
    stim_row_t    dir_tab [$];
    int           errors    = 0;
    int           checked   = 0;
    int           sent      = 0;
    bit           steady_in = 1'b0;   // sender offers back to back while set

    wildcard_pattern_matcher #(
        .MAX_PATTERN (wpm_pkg::MAX_PATTERN_DEF)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    // Advance the predictor by one accepted item. Returns 1 when the item
    // produces a result transaction, with the expected flags in 'flags'.
    function automatic bit step_matcher(input wpm_pkg::cmd_t cmd, input logic [7:0] sym,
                                        output match_flags_t flags);
        logic [63:0] next_row;
        logic        left_new;
        logic        left_old;
        logic        self_old;
        logic        hit;
        int          k;
        flags    = '0;
        next_row = '0;
        case (cmd)
            wpm_pkg::CMD_CLEAR:
            begin
                pat_len    = 0;
                live_row   = '0;
                empty_live = 1'b0;
                dropped    = 1'b0;
                return 1'b0;
            end
            wpm_pkg::CMD_APPEND:
            begin
                if (pat_len < wpm_pkg::MAX_PATTERN_DEF)
                begin
                    pat_mem[pat_len] = sym;
                    pat_len++;
                end
                else
                    dropped = 1'b1;
                // appending always cancels any text in progress
                live_row   = '0;
                empty_live = 1'b0;
                return 1'b0;
            end
            wpm_pkg::CMD_BEGIN:
            begin
                // only the leading run of stars matches the empty text
                empty_live = 1'b1;
                for (k = 0; k < pat_len; k++)
                begin
                    if (pat_mem[k] != wpm_pkg::SYM_STAR)
                        break;
                    next_row[k] = 1'b1;
                end
                live_row = next_row;
            end
            default:
            begin
                left_new = 1'b0;
                left_old = empty_live;
                for (k = 0; k < pat_len; k++)
                begin
                    self_old = live_row[k];
                    if (pat_mem[k] == wpm_pkg::SYM_STAR)
                        hit = self_old | left_new;
                    else if (pat_mem[k] == wpm_pkg::SYM_ANY)
                        hit = left_old;
                    else
                        hit = left_old && (pat_mem[k] == sym);
                    next_row[k] = hit;
                    left_new    = hit;
                    left_old    = self_old;
                end
                live_row   = next_row;
                empty_live = 1'b0;
            end
        endcase
        flags.matched  = (pat_len == 0) ? empty_live : live_row[pat_len - 1];
        flags.overflow = dropped;
        return 1'b1;
    endfunction

    // Mostly short idles, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(6, 20);
    endfunction

    // Text bytes lean on a small alphabet so that literal pattern bytes hit.
    function automatic logic [7:0] pick_text_byte();
        if ($urandom_range(0, 4) == 0)
            return 8'($urandom_range(0, 255));
        return 8'h61 + 8'($urandom_range(0, 2));
    endfunction

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic add_row(input wpm_pkg::cmd_t cmd, input logic [7:0] sym, input int reps,
                           input bit fixed, input logic matched, input logic overflow);
        stim_row_t row;
        row.cmd            = cmd;
        row.sym            = sym;
        row.reps           = reps;
        row.fixed          = fixed;
        row.flags.matched  = matched;
        row.flags.overflow = overflow;
        dir_tab.insert(dir_tab.size(), row);
    endtask

    // Offer one item, hold it until the handshake, then update the predictor.
    // tvalid stays high across back-to-back items: one assignment per edge.
    task automatic send_item(input wpm_pkg::cmd_t cmd, input logic [7:0] sym,
                             input bit fixed, input match_flags_t fixed_flags);
        int           gap;
        match_flags_t flags;
        gap = steady_in ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sym;
        s_axis_tuser  <= cmd;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (step_matcher(cmd, sym, flags))
            pending_flags.insert(pending_flags.size(), fixed ? fixed_flags : flags);
        sent++;
    endtask

    // Result checker: compare each accepted transaction with the oldest
    // expectation.
    always @(posedge clk)
    begin : result_check
        match_flags_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            checked++;
            if (pending_flags.size() == 0)
                report_mismatch($sformatf("unexpected result tdata=%02h", m_axis_tdata));
            else
            begin
                want = pending_flags.pop_front();
                if (m_axis_tdata[0] !== want.matched)
                    report_mismatch($sformatf("matched got %b want %b",
                                              m_axis_tdata[0], want.matched));
                if (m_axis_tdata[1] !== want.overflow)
                    report_mismatch($sformatf("overflow got %b want %b",
                                              m_axis_tdata[1], want.overflow));
                if (m_axis_tdata[7:2] !== 6'd0)
                    report_mismatch($sformatf("pad bits got %02h", m_axis_tdata[7:2]));
            end
        end
    end

    // Result sink: random ready/stall runs, plus one long hold-off so the
    // pipeline fills and the input side backs up.
    initial
    begin : result_sink
        int run;
        int gap;
        bit held;
        held = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (!held && checked >= HOLD_AFTER)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                held = 1'b1;
            end
            m_axis_tready <= 1'b1;
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 12);
            repeat (run) @(posedge clk);
            gap = pick_gap();
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("** wildcard_pattern_matcher: FAILED **");
        $finish;
    end

    initial
    begin : stimulus
        match_flags_t none;
        logic [7:0]   pat_q [$];
        logic [7:0]   txt_q [$];
        int           plen;
        int           r;
        int           k;
        none = '0;

        // Directed table. Rows with typed flags are obvious from the rules;
        // the rest fall back to the predictor.
        add_row(wpm_pkg::CMD_BEGIN,  8'h00,  1, 1, 1'b1, 1'b0); // empty pattern, empty text
        add_row(wpm_pkg::CMD_TEXT,   8'h00,  1, 1, 1'b0, 1'b0); // empty pattern, one byte
        add_row(wpm_pkg::CMD_TEXT,   8'hFF,  1, 1, 1'b0, 1'b0);
        add_row(wpm_pkg::CMD_CLEAR,  8'hFF,  1, 0, 1'b0, 1'b0);
        add_row(wpm_pkg::CMD_TEXT,   8'h55,  1, 1, 1'b0, 1'b0); // text with no begin
        add_row(wpm_pkg::CMD_APPEND, 8'h61,  1, 0, 1'b0, 1'b0);
        add_row(wpm_pkg::CMD_APPEND, wpm_pkg::SYM_ANY, 1, 0, 1'b0, 1'b0);
        add_row(wpm_pkg::CMD_APPEND, wpm_pkg::SYM_STAR, 1, 0, 1'b0, 1'b0);
        add_row(wpm_pkg::CMD_APPEND, 8'hFF,  1, 0, 1'b0, 1'b0);
        add_row(wpm_pkg::CMD_BEGIN,  8'hAA,  1, 1, 1'b0, 1'b0); // leading literal: no match
        add_row(wpm_pkg::CMD_TEXT,   8'h61,  1, 0, 1'b0, 1'b0);
        add_row(wpm_pkg::CMD_TEXT,   8'h00,  1, 0, 1'b0, 1'b0);
        add_row(wpm_pkg::CMD_TEXT,   wpm_pkg::SYM_STAR, 1, 0, 1'b0, 1'b0); // star as text
        add_row(wpm_pkg::CMD_TEXT,   8'hFF,  1, 0, 1'b0, 1'b0);
        add_row(wpm_pkg::CMD_TEXT,   8'hFF,  1, 0, 1'b0, 1'b0);
        add_row(wpm_pkg::CMD_APPEND, 8'h00,  1, 0, 1'b0, 1'b0); // append cancels the text
        add_row(wpm_pkg::CMD_TEXT,   8'h61,  1, 1, 1'b0, 1'b0);
        add_row(wpm_pkg::CMD_BEGIN,  8'h00,  1, 0, 1'b0, 1'b0);
        add_row(wpm_pkg::CMD_CLEAR,  8'h00,  1, 0, 1'b0, 1'b0);
        add_row(wpm_pkg::CMD_APPEND, wpm_pkg::SYM_STAR, wpm_pkg::MAX_PATTERN_DEF,
                0, 1'b0, 1'b0); // fill store
        add_row(wpm_pkg::CMD_APPEND, 8'h7E,  2, 0, 1'b0, 1'b0); // dropped, flag overflow
        add_row(wpm_pkg::CMD_BEGIN,  8'h55,  1, 1, 1'b1, 1'b1);
        add_row(wpm_pkg::CMD_TEXT,   8'h80,  1, 1, 1'b1, 1'b1);
        add_row(wpm_pkg::CMD_CLEAR,  8'h00,  1, 0, 1'b0, 1'b0); // clear drops overflow
        add_row(wpm_pkg::CMD_BEGIN,  8'h00,  1, 1, 1'b1, 1'b0);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
            repeat (dir_tab[i].reps)
                send_item(dir_tab[i].cmd, dir_tab[i].sym, dir_tab[i].fixed,
                          dir_tab[i].flags);

        // Random sessions: mostly clear/load/begin/text with random content,
        // sometimes raw command noise.
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            steady_in = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 8))
                    send_item(wpm_pkg::cmd_t'($urandom_range(0, 3)),
                              8'($urandom_range(0, 255)), 1'b0, none);
            end
            else
            begin
                r = $urandom_range(0, 19);
                if (r == 0)
                    plen = $urandom_range(wpm_pkg::MAX_PATTERN_DEF - 4,
                                          wpm_pkg::MAX_PATTERN_DEF + 6);
                else if (r < 3)
                    plen = 0;
                else
                    plen = $urandom_range(1, 8);
                pat_q.delete();
                for (k = 0; k < plen; k++)
                begin
                    r = $urandom_range(0, 9);
                    if (r < 2)
                        pat_q.insert(pat_q.size(), wpm_pkg::SYM_STAR);
                    else if (r == 2)
                        pat_q.insert(pat_q.size(), wpm_pkg::SYM_ANY);
                    else if (r == 3)
                        pat_q.insert(pat_q.size(), 8'($urandom_range(0, 255)));
                    else
                        pat_q.insert(pat_q.size(), 8'h61 + 8'($urandom_range(0, 2)));
                end
                send_item(wpm_pkg::CMD_CLEAR, 8'($urandom_range(0, 255)), 1'b0, none);
                foreach (pat_q[i])
                    send_item(wpm_pkg::CMD_APPEND, pat_q[i], 1'b0, none);
                repeat ($urandom_range(1, 3))
                begin
                    txt_q.delete();
                    if ($urandom_range(0, 1))
                    begin
                        // expand the pattern into a text that should match
                        foreach (pat_q[i])
                        begin
                            if (pat_q[i] == wpm_pkg::SYM_STAR)
                                repeat ($urandom_range(0, 3))
                                    txt_q.insert(txt_q.size(), pick_text_byte());
                            else if (pat_q[i] == wpm_pkg::SYM_ANY)
                                txt_q.insert(txt_q.size(), 8'($urandom_range(0, 255)));
                            else
                                txt_q.insert(txt_q.size(), pat_q[i]);
                        end
                    end
                    else
                        repeat ($urandom_range(0, 12))
                            txt_q.insert(txt_q.size(), pick_text_byte());
                    // corrupt one byte now and then
                    if (txt_q.size() > 0 && $urandom_range(0, 3) == 0)
                        txt_q[$urandom_range(0, txt_q.size() - 1)] = pick_text_byte();
                    send_item(wpm_pkg::CMD_BEGIN, 8'($urandom_range(0, 255)), 1'b0, none);
                    foreach (txt_q[i])
                        send_item(wpm_pkg::CMD_TEXT, txt_q[i], 1'b0, none);
                end
            end
        end
        s_axis_tvalid <= 1'b0;

        // Drain: wait for every expected result, then wait on for DRAIN_CYCLES to
        // catch anything spurious.
        while (pending_flags.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0 && pending_flags.size() == 0)
            $display("** wildcard_pattern_matcher: PASSED **");
        else
            $display("** wildcard_pattern_matcher: FAILED **");
        $finish;
    end

endmodule
